@@ src/ip_flow_table_tracker_defines.svh @@
// Assertion macros used by the checker module
`ifndef IP_FLOW_TABLE_TRACKER_DEFINES_SVH
`define IP_FLOW_TABLE_TRACKER_DEFINES_SVH

// same-cycle implication
`define FTT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FTT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/ftt_pkg.sv @@
package ftt_pkg;

    localparam int TABLE_ENTRIES = 32;
    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    localparam int S_DATA_W = 112;
    localparam int M_DATA_W = 216;
    localparam int ADDR_W = 4;

    localparam logic [1:0] REG_HALF = 2'd0;
    localparam logic [1:0] REG_FULL = 2'd1;
    localparam logic [1:0] REG_CHECK = 2'd2;

    localparam logic [47:0] BYTES_MAX = 48'hFFFF_FFFF_FFFF;
    localparam logic [31:0] PKTS_MAX = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        EV_CREATED = 2'd0,
        EV_DELETED = 2'd1,
        EV_COUNTED = 2'd2,
        EV_DROPPED = 2'd3
    } t_kind;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_AGE_RD,
        ST_AGE_EV,
        ST_LK_SCAN,
        ST_LK_WAIT,
        ST_LK_DEC,
        ST_HIT_EV,
        ST_REV_WR,
        ST_FL_SCAN,
        ST_FL_WAIT,
        ST_FL_DEC,
        ST_FL_EV,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [31:0] src;
        logic [31:0] dst;
        logic        full;
        logic        dir;
        logic [31:0] first_time;
        logic [31:0] last_time;
        logic [31:0] packets;
        logic [47:0] bytes;
    } t_entry;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] src;
        logic [31:0] dst;
        logic        full;
        logic        dir;
        logic [31:0] packets;
        logic [47:0] bytes;
        logic [31:0] first_time;
        logic [31:0] last_time;
        logic        last_res;
    } t_result;

    function automatic t_result mk_result(t_kind k, t_entry e);
        t_result r;
        r.kind       = k;
        r.src        = e.src;
        r.dst        = e.dst;
        r.full       = e.full;
        r.dir        = e.dir;
        r.packets    = e.packets;
        r.bytes      = e.bytes;
        r.first_time = e.first_time;
        r.last_time  = e.last_time;
        r.last_res   = 1'b0;
        return r;
    endfunction

endpackage

@@ src/ip_flow_table_tracker.sv @@
// IPv4 flow table tracker.
// Input stream: s_tdata = {packet_bytes, dst_ip, src_ip, timestamp_sec},
// s_tuser = {has_ip, command}. Output stream: one item per flow event,
// m_tuser = event_kind, m_tlast marks the final item caused by an input item.
// Configuration over APB: half_timeout at 0x0, full_timeout at 0x4,
// check_interval at 0x8; write only while the block is idle.
// One input item is taken at a time; s_tready is high only when the previous
// item is done. Flow state sits in a TABLE_ENTRIES deep memory with a
// registered read; valid bits are flip-flops.
// Steps per packet: an accept step, an aging sweep of every entry when due,
// a lookup scan of the table, and a read-modify-write for a hit or for a new
// flow whose reverse exists. A flush walks the table once per removed flow.
// Reset empties the table, clears the last sweep time and loads the default
// timeouts. When the receiver stalls, one result waits in the output
// register and one more is held inside; the sequencer then holds.
module ip_flow_table_tracker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // timestamp_sec, src_ip, dst_ip, packet_bytes
    input  logic [ftt_pkg::S_DATA_W-1:0]  s_tdata,
    // command, has_ip
    input  logic [1:0]                    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // flow_src, flow_dst, flow_full, server_to_client, packet_total,
    // byte_total, first_seen_sec, last_seen_sec, zero pad
    output logic [ftt_pkg::M_DATA_W-1:0]  m_tdata,
    // event_kind
    output logic [1:0]                    m_tuser,
    output logic                          m_tlast,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ftt_pkg::ADDR_W-1:0]    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import ftt_pkg::*;

    t_state r_state, n_state;

    logic [15:0] r_half_to, r_full_to, r_check;
    logic [31:0] r_last_check;

    logic        r_cmd, r_has_ip;
    logic [31:0] r_now, r_src, r_dst;
    logic [15:0] r_len;

    t_entry r_mem [TABLE_ENTRIES];
    t_entry r_rd;
    logic [TABLE_ENTRIES-1:0] r_valid;

    logic [IDX_W-1:0] r_idx, r_ridx;
    logic             r_rv;
    logic             r_s_hit, r_r_hit, r_best_v;
    logic [IDX_W-1:0] r_s_idx, r_r_idx, r_best_idx;
    logic [31:0]      r_best_time;

    t_result r_pend, r_o;
    logic    r_pend_v, r_o_valid;

    logic [IDX_W-1:0] rd_addr, wr_addr, clr_idx, free_idx;
    logic             wr_en, clr_en, set_en, push, free_hit, can_push;
    t_entry           wr_data, new_e, upd_e, rev_e, drop_e;
    t_result          push_res, fin_res;

    logic [32:0] since, idle;
    logic [48:0] byte_sum;
    logic        age_go, expire, reg_wr;
    logic [15:0] cur_to;

    assign s_tready = (r_state == ST_IDLE);
    assign pready   = 1'b1;
    assign reg_wr   = psel && penable && pwrite;

    assign m_tvalid = r_o_valid;
    assign m_tuser  = r_o.kind;
    assign m_tlast  = r_o.last_res;
    assign m_tdata  = {6'b0, r_o.last_time, r_o.first_time, r_o.bytes, r_o.packets,
                       r_o.dir, r_o.full, r_o.dst, r_o.src};

    always_comb begin
        unique case (paddr[ADDR_W-1:2])
            REG_HALF:  prdata = {16'b0, r_half_to};
            REG_FULL:  prdata = {16'b0, r_full_to};
            REG_CHECK: prdata = {16'b0, r_check};
            default:   prdata = 32'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd <= r_mem[rd_addr];
    end

    always_comb begin
        free_hit = 1'b0;
        free_idx = '0;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_hit = 1'b1;
                free_idx = IDX_W'(i);
            end
        end
    end

    assign since  = {1'b0, s_tdata[31:0]} - {1'b0, r_last_check};
    assign age_go = (r_check != 16'd0) && !since[32] && (since[31:0] >= {16'b0, r_check});
    assign idle   = {1'b0, r_now} - {1'b0, r_rd.last_time};
    assign cur_to = r_rd.full ? r_full_to : r_half_to;
    assign expire = r_valid[r_idx] && !idle[32] && (idle[31:0] >= {16'b0, cur_to});

    assign can_push = !r_pend_v || !r_o_valid || m_tready;
    assign byte_sum = {1'b0, r_rd.bytes} + {33'b0, r_len};

    always_comb begin
        fin_res          = r_pend;
        fin_res.last_res = 1'b1;
    end

    always_comb begin
        new_e.src        = r_src;
        new_e.dst        = r_dst;
        new_e.full       = r_r_hit;
        new_e.dir        = r_r_hit;
        new_e.first_time = r_now;
        new_e.last_time  = r_now;
        new_e.packets    = 32'd1;
        new_e.bytes      = {32'b0, r_len};

        drop_e.src        = r_src;
        drop_e.dst        = r_dst;
        drop_e.full       = 1'b0;
        drop_e.dir        = 1'b0;
        drop_e.first_time = r_now;
        drop_e.last_time  = r_now;
        drop_e.packets    = 32'd0;
        drop_e.bytes      = 48'd0;

        upd_e           = r_rd;
        upd_e.last_time = r_now;
        upd_e.packets   = (r_rd.packets == PKTS_MAX) ? PKTS_MAX : r_rd.packets + 32'd1;
        upd_e.bytes     = byte_sum[48] ? BYTES_MAX : byte_sum[47:0];

        rev_e      = r_rd;
        rev_e.full = 1'b1;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (s_tuser[0]) begin
                        n_state = ST_FL_SCAN;
                    end else if (age_go) begin
                        n_state = ST_AGE_RD;
                    end else if (s_tuser[1]) begin
                        n_state = ST_LK_SCAN;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_AGE_RD: n_state = ST_AGE_EV;
            ST_AGE_EV: begin
                if (!expire || can_push) begin
                    if (r_idx == LAST_IDX) begin
                        n_state = r_has_ip ? ST_LK_SCAN : ST_DONE;
                    end else begin
                        n_state = ST_AGE_RD;
                    end
                end
            end
            ST_LK_SCAN: if (r_idx == LAST_IDX) n_state = ST_LK_WAIT;
            ST_LK_WAIT: n_state = ST_LK_DEC;
            ST_LK_DEC: begin
                if (r_s_hit) begin
                    n_state = ST_HIT_EV;
                end else if (can_push) begin
                    n_state = (free_hit && r_r_hit) ? ST_REV_WR : ST_DONE;
                end
            end
            ST_HIT_EV: if (can_push) n_state = ST_DONE;
            ST_REV_WR: n_state = ST_DONE;
            ST_FL_SCAN: if (r_idx == LAST_IDX) n_state = ST_FL_WAIT;
            ST_FL_WAIT: n_state = ST_FL_DEC;
            ST_FL_DEC: n_state = r_best_v ? ST_FL_EV : ST_DONE;
            ST_FL_EV: if (can_push) n_state = ST_FL_SCAN;
            ST_DONE: if (!r_pend_v || !r_o_valid || m_tready) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        push     = 1'b0;
        push_res = mk_result(EV_DELETED, r_rd);
        wr_en    = 1'b0;
        wr_addr  = r_idx;
        wr_data  = r_rd;
        rd_addr  = r_idx;
        clr_en   = 1'b0;
        clr_idx  = r_idx;
        set_en   = 1'b0;
        unique case (r_state)
            ST_AGE_EV: begin
                if (expire && can_push) begin
                    push   = 1'b1;
                    clr_en = 1'b1;
                end
            end
            ST_LK_DEC: begin
                if (r_s_hit) begin
                    rd_addr = r_s_idx;
                end else begin
                    rd_addr = r_r_idx;
                    if (can_push) begin
                        push = 1'b1;
                        if (free_hit) begin
                            wr_en    = 1'b1;
                            wr_addr  = free_idx;
                            wr_data  = new_e;
                            set_en   = 1'b1;
                            push_res = mk_result(EV_CREATED, new_e);
                        end else begin
                            push_res = mk_result(EV_DROPPED, drop_e);
                        end
                    end
                end
            end
            ST_HIT_EV: begin
                rd_addr = r_s_idx;
                if (can_push) begin
                    push     = 1'b1;
                    wr_en    = 1'b1;
                    wr_addr  = r_s_idx;
                    wr_data  = upd_e;
                    push_res = mk_result(EV_COUNTED, upd_e);
                end
            end
            ST_REV_WR: begin
                wr_en   = 1'b1;
                wr_addr = r_r_idx;
                wr_data = rev_e;
            end
            ST_FL_DEC: rd_addr = r_best_idx;
            ST_FL_EV: begin
                rd_addr = r_best_idx;
                if (can_push) begin
                    push    = 1'b1;
                    clr_en  = 1'b1;
                    clr_idx = r_best_idx;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_valid      <= '0;
            r_last_check <= 32'd0;
            r_half_to    <= 16'd60;
            r_full_to    <= 16'd300;
            r_check      <= 16'd1;
            r_pend_v     <= 1'b0;
            r_o_valid    <= 1'b0;
            r_rv         <= 1'b0;
            r_idx        <= '0;
        end else begin
            r_state <= n_state;

            if (reg_wr) begin
                unique case (paddr[ADDR_W-1:2])
                    REG_HALF:  r_half_to <= pwdata[15:0];
                    REG_FULL:  r_full_to <= pwdata[15:0];
                    REG_CHECK: r_check   <= pwdata[15:0];
                    default: ;
                endcase
            end

            if (clr_en) r_valid[clr_idx] <= 1'b0;
            if (set_en) r_valid[free_idx] <= 1'b1;

            r_rv <= (r_state == ST_LK_SCAN) || (r_state == ST_FL_SCAN);

            priority case (r_state)
                ST_IDLE: begin
                    r_idx <= '0;
                    if (s_tvalid && !s_tuser[0] && age_go) r_last_check <= s_tdata[31:0];
                end
                ST_AGE_EV: begin
                    if (!expire || can_push) begin
                        r_idx <= (r_idx == LAST_IDX) ? '0 : r_idx + 1'b1;
                    end
                end
                ST_LK_SCAN, ST_FL_SCAN: begin
                    if (r_idx != LAST_IDX) r_idx <= r_idx + 1'b1;
                end
                ST_FL_EV: begin
                    if (can_push) r_idx <= '0;
                end
                default: ;
            endcase

            if (push) begin
                r_pend   <= push_res;
                r_pend_v <= 1'b1;
                if (r_pend_v) begin
                    r_o       <= r_pend;
                    r_o_valid <= 1'b1;
                end else if (m_tready) begin
                    r_o_valid <= 1'b0;
                end
            end else if (r_state == ST_DONE && r_pend_v && (!r_o_valid || m_tready)) begin
                r_o       <= fin_res;
                r_o_valid <= 1'b1;
                r_pend_v  <= 1'b0;
            end else if (m_tready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ridx <= r_idx;
        if (r_state == ST_IDLE) begin
            r_cmd    <= s_tuser[0];
            r_has_ip <= s_tuser[1];
            r_now    <= s_tdata[31:0];
            r_src    <= s_tdata[63:32];
            r_dst    <= s_tdata[95:64];
            r_len    <= s_tdata[111:96];
            r_s_hit  <= 1'b0;
            r_r_hit  <= 1'b0;
            r_best_v <= 1'b0;
        end else if (r_state == ST_FL_EV) begin
            if (can_push) r_best_v <= 1'b0;
        end else if (r_rv && r_valid[r_ridx]) begin
            if (r_cmd) begin
                if (!r_best_v || (r_rd.last_time < r_best_time)) begin
                    r_best_v    <= 1'b1;
                    r_best_idx  <= r_ridx;
                    r_best_time <= r_rd.last_time;
                end
            end else begin
                if (!r_s_hit && r_rd.src == r_src && r_rd.dst == r_dst) begin
                    r_s_hit <= 1'b1;
                    r_s_idx <= r_ridx;
                end
                if (!r_r_hit && r_rd.src == r_dst && r_rd.dst == r_src) begin
                    r_r_hit <= 1'b1;
                    r_r_idx <= r_ridx;
                end
            end
        end
    end

endmodule

@@ src/ftt_checker.sv @@
`include "ip_flow_table_tracker_defines.svh"

module ftt_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [ftt_pkg::M_DATA_W-1:0]  m_tdata,
    input logic [1:0]                    m_tuser,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic                          m_tlast
);
    import ftt_pkg::*;

    `FTT_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "output item dropped")
    `FTT_ASSERT_NEXT(a_one_item, s_tvalid && s_tready, !s_tready, "second item taken early")
    `FTT_ASSERT_NOW(a_final_kind, m_tvalid && m_tuser != EV_DELETED, m_tlast, "event not final")
    `FTT_ASSERT_NOW(a_half_dir, m_tvalid && !m_tdata[64], !m_tdata[65], "half flow reversed")

endmodule

bind ip_flow_table_tracker ftt_checker u_ftt_checker (.*);

@@ tb/sv/flow_event_checker.sv @@
module flow_event_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_tvalid,
    input  logic                         s_tready,
    input  logic [ftt_pkg::S_DATA_W-1:0] s_tdata,
    input  logic [1:0]                   s_tuser,
    input  logic                         m_tvalid,
    input  logic                         m_tready,
    input  logic [ftt_pkg::M_DATA_W-1:0] m_tdata,
    input  logic [1:0]                   m_tuser,
    input  logic                         m_tlast,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ftt_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                  pwdata,
    input  logic                         pready,
    output int                           o_errors,
    output int                           o_pending,
    output int                           o_events
);
    timeunit 1ns;
    timeprecision 1ps;
    import ftt_pkg::*;

    localparam int N = TABLE_ENTRIES;

    logic        tbl_valid [N];
    logic [63:0] tbl_key   [N];
    logic        tbl_full  [N];
    logic        tbl_dir   [N];
    logic [31:0] tbl_first [N];
    logic [31:0] tbl_last  [N];
    logic [31:0] tbl_pkts  [N];
    logic [47:0] tbl_bytes [N];
    logic [31:0] sweep_time;
    logic [15:0] half_to, full_to, sweep_every;

    t_result flow_events_q[$];

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
        o_errors++;
    endtask

    function automatic t_result slot_event(t_kind k, int s);
        t_result r;
        r.kind       = k;
        r.src        = tbl_key[s][63:32];
        r.dst        = tbl_key[s][31:0];
        r.full       = tbl_full[s];
        r.dir        = tbl_dir[s];
        r.packets    = tbl_pkts[s];
        r.bytes      = tbl_bytes[s];
        r.first_time = tbl_first[s];
        r.last_time  = tbl_last[s];
        r.last_res   = 1'b0;
        return r;
    endfunction

    function automatic int lookup(logic [63:0] key);
        for (int i = 0; i < N; i++)
            if (tbl_valid[i] && tbl_key[i] == key) return i;
        return -1;
    endfunction

    task automatic predict_flow_events(input logic cmd, input logic [31:0] now,
                                       input logic has_ip, input logic [31:0] src,
                                       input logic [31:0] dst, input logic [15:0] len);
        int best, s, r, n0;
        longint since, idle, tmo;
        logic [63:0] key, rkey;
        logic [48:0] sum;
        t_result d;
        n0 = flow_events_q.size();
        if (cmd) begin
            forever begin
                best = -1;
                for (int i = 0; i < N; i++)
                    if (tbl_valid[i] && (best < 0 || tbl_last[i] < tbl_last[best])) best = i;
                if (best < 0) break;
                flow_events_q.push_back(slot_event(EV_DELETED, best));
                tbl_valid[best] = 1'b0;
            end
        end else begin
            since = longint'(now) - longint'(sweep_time);
            if (sweep_every != 0 && since >= longint'(sweep_every)) begin
                for (int i = 0; i < N; i++) begin
                    if (!tbl_valid[i]) continue;
                    idle = longint'(now) - longint'(tbl_last[i]);
                    tmo = tbl_full[i] ? longint'(full_to) : longint'(half_to);
                    if (idle >= tmo) begin
                        flow_events_q.push_back(slot_event(EV_DELETED, i));
                        tbl_valid[i] = 1'b0;
                    end
                end
                sweep_time = now;
            end
            if (has_ip) begin
                key = {src, dst};
                rkey = {dst, src};
                s = lookup(key);
                if (s >= 0) begin
                    tbl_last[s] = now;
                    if (tbl_pkts[s] != PKTS_MAX) tbl_pkts[s]++;
                    sum = {1'b0, tbl_bytes[s]} + {33'b0, len};
                    tbl_bytes[s] = sum > {1'b0, BYTES_MAX} ? BYTES_MAX : sum[47:0];
                    flow_events_q.push_back(slot_event(EV_COUNTED, s));
                end else begin
                    r = lookup(rkey);
                    for (int i = 0; i < N; i++)
                        if (!tbl_valid[i]) begin
                            s = i;
                            break;
                        end
                    if (s < 0) begin
                        d = '0;
                        d.kind = EV_DROPPED;
                        d.src = src;
                        d.dst = dst;
                        d.first_time = now;
                        d.last_time = now;
                        flow_events_q.push_back(d);
                    end else begin
                        tbl_valid[s] = 1'b1;
                        tbl_key[s] = key;
                        tbl_first[s] = now;
                        tbl_last[s] = now;
                        tbl_pkts[s] = 32'd1;
                        tbl_bytes[s] = 48'(len);
                        tbl_full[s] = (r >= 0);
                        tbl_dir[s] = (r >= 0);
                        if (r >= 0) tbl_full[r] = 1'b1;
                        flow_events_q.push_back(slot_event(EV_CREATED, s));
                    end
                end
            end
        end
        if (flow_events_q.size() > n0) flow_events_q[flow_events_q.size()-1].last_res = 1'b1;
    endtask

    initial begin
        o_errors = 0;
        o_events = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin
        t_result w;
        if (!i_rst_n) begin
            for (int i = 0; i < N; i++) tbl_valid[i] = 1'b0;
            sweep_time = '0;
            half_to = 16'd60;
            full_to = 16'd300;
            sweep_every = 16'd1;
            flow_events_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                o_events++;
                if (flow_events_q.size() == 0) begin
                    $display("%0t unexpected result kind %0d", $realtime, m_tuser);
                    o_errors++;
                end else begin
                    w = flow_events_q.pop_front();
                    if (m_tuser !== w.kind) report("event_kind", 64'(m_tuser), 64'(w.kind));
                    if (m_tdata[31:0] !== w.src)
                        report("flow_src", 64'(m_tdata[31:0]), 64'(w.src));
                    if (m_tdata[63:32] !== w.dst)
                        report("flow_dst", 64'(m_tdata[63:32]), 64'(w.dst));
                    if (m_tdata[64] !== w.full)
                        report("flow_full", 64'(m_tdata[64]), 64'(w.full));
                    if (m_tdata[65] !== w.dir)
                        report("server_to_client", 64'(m_tdata[65]), 64'(w.dir));
                    if (m_tdata[97:66] !== w.packets)
                        report("packet_total", 64'(m_tdata[97:66]), 64'(w.packets));
                    if (m_tdata[145:98] !== w.bytes)
                        report("byte_total", 64'(m_tdata[145:98]), 64'(w.bytes));
                    if (m_tdata[177:146] !== w.first_time)
                        report("first_seen_sec", 64'(m_tdata[177:146]), 64'(w.first_time));
                    if (m_tdata[209:178] !== w.last_time)
                        report("last_seen_sec", 64'(m_tdata[209:178]), 64'(w.last_time));
                    if (m_tlast !== w.last_res)
                        report("last_result", 64'(m_tlast), 64'(w.last_res));
                end
            end
            if (s_tvalid && s_tready)
                predict_flow_events(s_tuser[0], s_tdata[31:0], s_tuser[1], s_tdata[63:32],
                                    s_tdata[95:64], s_tdata[111:96]);
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_HALF:  half_to = pwdata[15:0];
                    REG_FULL:  full_to = pwdata[15:0];
                    REG_CHECK: sweep_every = pwdata[15:0];
                    default: ;
                endcase
            end
        end
        o_pending = flow_events_q.size();
    end
endmodule

@@ tb/sv/ip_flow_table_tracker_tb.sv @@
module ip_flow_table_tracker_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ftt_pkg::*;

    localparam logic CMD_PACKET = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata = '0;
    logic [1:0]            s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic [1:0]            m_tuser;
    logic                  m_tlast;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [ADDR_W-1:0]     paddr = '0;
    logic [31:0]           pwdata = '0;
    logic [31:0]           prdata;
    logic                  pready;

    int errors, pending, events;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    bit rx_hold = 1'b0;
    int items_sent = 0;
    int settings = 0;
    logic [31:0] clock_sec = 32'd0;
    logic [31:0] hosts[6];

    ip_flow_table_tracker dut (.*);

    flow_event_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .pready(pready),
        .o_errors(errors), .o_pending(pending), .o_events(events)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(negedge i_clk)
        m_tready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);

    initial begin
        #(12 * 800000);
        $display("ip_flow_table_tracker_tb: errors");
        $finish;
    end

    task automatic send_item(input logic cmd, input logic [31:0] ts, input logic has_ip,
                             input logic [31:0] src, input logic [31:0] dst,
                             input logic [15:0] len);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_tvalid = 1'b1;
        s_tdata = {len, dst, src, ts};
        s_tuser = {has_ip, cmd};
        do @(posedge i_clk); while (!s_tready);
        @(negedge i_clk);
        s_tvalid = 1'b0;
        items_sent++;
    endtask

    task automatic settle();
        while (pending != 0 || !s_tready) @(negedge i_clk);
        repeat (200) @(negedge i_clk);
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [15:0] value);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = ADDR_W'({idx, 2'b00});
        pwdata = {16'h0, value};
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic set_timeouts(input logic [15:0] h, input logic [15:0] f, input logic [15:0] c);
        settle();
        apb_write(REG_HALF, h);
        apb_write(REG_FULL, f);
        apb_write(REG_CHECK, c);
        settings++;
    endtask

    task automatic send_packet(input logic [31:0] src, input logic [31:0] dst);
        send_item(CMD_PACKET, clock_sec, 1'b1, src, dst, 16'($urandom));
    endtask

    task automatic random_items(input int count);
        int pick;
        for (int k = 0; k < count; k++) begin
            pick = $urandom_range(99);
            clock_sec += $urandom_range(0, 4);
            if (pick < 8)
                send_item(CMD_FLUSH, $urandom, 1'($urandom_range(1)), $urandom, $urandom,
                          16'($urandom));
            else if (pick < 16)
                send_item(CMD_PACKET, clock_sec, 1'b0, $urandom, $urandom, 16'($urandom));
            else if (pick < 20)
                send_item(CMD_PACKET, $urandom, 1'b1, $urandom, $urandom, 16'($urandom));
            else
                send_packet(hosts[$urandom_range(5)], hosts[$urandom_range(5)]);
        end
    endtask

    initial begin
        foreach (hosts[i]) hosts[i] = $urandom;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        set_timeouts(16'd5, 16'd20, 16'd1);
        send_item(CMD_FLUSH, 32'd0, 1'b0, 32'd0, 32'd0, 16'd0);
        send_item(CMD_PACKET, 32'd0, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
        send_item(CMD_PACKET, 32'd1, 1'b1, hosts[0], hosts[1], 16'd0);
        send_item(CMD_PACKET, 32'd2, 1'b1, hosts[1], hosts[0], 16'hFFFF);
        send_item(CMD_PACKET, 32'd2, 1'b1, hosts[0], hosts[1], 16'd64);
        send_item(CMD_PACKET, 32'd3, 1'b1, hosts[2], hosts[2], 16'd100);
        send_item(CMD_PACKET, 32'd3, 1'b1, hosts[2], hosts[2], 16'hFFFF);
        send_item(CMD_PACKET, 32'd4, 1'b1, 32'd0, 32'hFFFF_FFFF, 16'd1);
        send_item(CMD_PACKET, 32'd4, 1'b1, hosts[3], hosts[4], 16'd1);
        send_item(CMD_PACKET, 32'd9, 1'b1, hosts[3], hosts[4], 16'd2);
        send_item(CMD_PACKET, 32'd25, 1'b0, 32'd0, 32'd0, 16'd0);
        send_item(CMD_PACKET, 32'd26, 1'b1, hosts[0], hosts[1], 16'd5);
        send_item(CMD_PACKET, 32'd26, 1'b1, hosts[5], hosts[0], 16'd5);
        send_item(CMD_PACKET, 32'd20, 1'b1, hosts[5], hosts[1], 16'd9);
        send_item(CMD_FLUSH, 32'd0, 1'b1, 32'd0, 32'd0, 16'd0);
        send_item(CMD_PACKET, 32'hFFFF_FFFF, 1'b1, hosts[1], hosts[2], 16'hFFFF);
        send_item(CMD_PACKET, 32'd30, 1'b1, hosts[1], hosts[2], 16'd3);
        send_item(CMD_FLUSH, 32'hFFFF_FFFF, 1'b0, 32'd0, 32'd0, 16'd0);

        set_timeouts(16'hFFFF, 16'hFFFF, 16'd0);
        clock_sec = 32'd100;
        for (int k = 0; k < TABLE_ENTRIES + 3; k++)
            send_packet(hosts[k % 6] + 32'(k), hosts[(k + 1) % 6]);
        send_item(CMD_FLUSH, 32'd0, 1'b0, 32'd0, 32'd0, 16'd0);

        set_timeouts(16'd0, 16'd0, 16'hFFFF);
        clock_sec = 32'd0;
        random_items(4);

        set_timeouts(16'($urandom_range(1, 12)), 16'($urandom_range(5, 40)),
                     16'($urandom_range(1, 4)));
        tx_idle_pct = 30;
        rx_idle_pct = 87;
        fork
            begin
                rx_hold = 1'b1;
                repeat (600) @(negedge i_clk);
                rx_hold = 1'b0;
            end
        join_none
        random_items(15);
        while (pending != 0) @(negedge i_clk);
        random_items(15);

        set_timeouts(16'($urandom_range(1, 12)), 16'($urandom_range(5, 40)),
                     16'($urandom_range(0, 3)));
        tx_idle_pct = 87;
        rx_idle_pct = 30;
        random_items(20);

        set_timeouts(16'($urandom_range(1, 12)), 16'($urandom_range(5, 40)), 16'd1);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        random_items(20);

        while (pending != 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);
        $display("Sent %0d input items under %0d timeout settings; %0d flow events checked",
                 items_sent, settings, events);
        if (errors == 0)
            $display("ip_flow_table_tracker_tb: clean");
        else
            $display("ip_flow_table_tracker_tb: errors");
        $finish;
    end
endmodule
